[rtl/hgc_pkg.sv]
// Shared types and constants for the hexagonal grid coordinate mapper.
package hgc_pkg;

  localparam int CW = 16;
  localparam int XW = CW + 2;
  localparam int NW = CW + 22;
  localparam int QW = CW + 10;
  localparam int DW = 22;
  localparam int SW = 8;

  localparam logic [11:0] RT3_NUM = 12'd3691;
  localparam logic [11:0] RT3_DEN = 12'd2131;
  localparam logic [12:0] RT3_DEN2 = 13'd4262;
  localparam logic [SW-1:0] CELL_RESET = 8'd3;

  typedef enum logic [1:0] {
    FN_S2V = 2'd0,
    FN_S2H = 2'd1,
    FN_V2S = 2'd2,
    FN_H2S = 2'd3
  } func_t;

  typedef struct packed {
    func_t                 func;
    logic signed [CW-1:0]  in_a;
    logic signed [CW-1:0]  in_b;
  } req_t;

  typedef struct packed {
    logic signed [CW-1:0]  out_a;
    logic signed [CW-1:0]  out_b;
    logic                  saturated;
  } res_t;

  typedef struct packed {
    func_t                 func;
    logic signed [CW-1:0]  a;
    logic signed [CW-1:0]  b;
    logic signed [NW-1:0]  alt;
  } side1_t;

  typedef struct packed {
    func_t                 func;
    logic signed [QW-1:0]  q1;
    logic signed [NW-1:0]  alt;
  } side2_t;

endpackage

[rtl/hgc_div.sv]
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
module hgc_div
  import hgc_pkg::*;
#(
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [NW-1:0]     num,
  input  logic [DW-1:0]            den,
  input  logic [SIDE_W-1:0]        side_in,
  output logic                     out_valid,
  output logic signed [NW-1:0]     quo,
  output logic [SIDE_W-1:0]        side_out
);

  logic              v  [0:NW+1];
  logic [NW-1:0]     nq [0:NW];
  logic [DW-1:0]     rm [0:NW];
  logic [DW-1:0]     dn [0:NW];
  logic              ng [0:NW];
  logic [SIDE_W-1:0] sd [0:NW+1];
  logic [NW-1:0]     mag;

  assign mag = num[NW-1] ? NW'(-num) : NW'(num);

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nq[0] <= mag;
      rm[0] <= '0;
      dn[0] <= den;
      ng[0] <= num[NW-1];
      sd[0] <= side_in;
    end
  end

  for (genvar i = 1; i <= NW; i++) begin : g_stage
    logic [DW:0] r2;
    logic [DW:0] rs;
    logic        ge;

    assign r2 = {rm[i-1], nq[i-1][NW-1]};
    assign ge = r2 >= {1'b0, dn[i-1]};
    assign rs = ge ? r2 - {1'b0, dn[i-1]} : r2;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= v[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rm[i] <= rs[DW-1:0];
        nq[i] <= {nq[i-1][NW-2:0], ge};
        dn[i] <= dn[i-1];
        ng[i] <= ng[i-1];
        sd[i] <= sd[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[NW+1] <= 1'b0;
    end else if (en) begin
      v[NW+1] <= v[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo       <= ng[NW] ? $signed(-nq[NW]) : $signed(nq[NW]);
      sd[NW+1]  <= sd[NW];
    end
  end

  assign out_valid = v[NW+1];
  assign side_out  = sd[NW+1];

endmodule

[rtl/hgc_front.sv]
// Front stages: operand selection and scaling ahead of the first division.
module hgc_front
  import hgc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  req_t                 req,
  input  logic [SW-1:0]        cell_size,
  output logic                 out_valid,
  output logic signed [NW-1:0] num,
  output logic [DW-1:0]        den,
  output side1_t               side
);

  logic                 v0, v1;
  req_t                 r0;
  logic signed [XW-1:0] x, x_next, y, y_next;
  logic [DW-1:0]        c, c_next, d, d_next;
  logic [SW:0]          f, f_next;
  side1_t               s1;
  logic [SW-1:0]        s;
  logic signed [XW-1:0] ax, bx, sx;
  logic signed [XW+DW:0] prod;
  logic signed [XW+SW+1:0] altp;

  assign s  = (cell_size == '0) ? SW'(1) : cell_size;
  assign ax = XW'(r0.in_a);
  assign bx = XW'(r0.in_b);
  assign sx = XW'($signed({1'b0, s}));

  always_comb begin
    x_next = '0;
    y_next = '0;
    c_next = '0;
    d_next = DW'(1);
    f_next = '0;
    case (r0.func)
      FN_S2V: begin
        x_next = ax + sx;
        c_next = DW'(RT3_DEN);
        d_next = DW'(RT3_NUM * s);
      end
      FN_S2H: begin
        x_next = bx + sx;
        c_next = DW'(1);
        d_next = DW'({s, 1'b0});
      end
      FN_V2S: begin
        x_next = ax;
        c_next = DW'(RT3_NUM * s);
        d_next = DW'(RT3_DEN);
        y_next = (bx <<< 1) + ax;
        f_next = (SW+1)'(s);
      end
      default: begin
        x_next = (ax <<< 1) + bx;
        c_next = DW'(RT3_DEN2 * s);
        d_next = DW'(RT3_NUM);
        y_next = bx;
        f_next = {s, 1'b0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0        <= in_valid;
      v1        <= v0;
      out_valid <= v1;
    end
  end

  assign prod = x * $signed({1'b0, c});
  assign altp = y * $signed({1'b0, f});

  always_ff @(posedge clk) begin
    if (en) begin
      r0       <= req;
      x        <= x_next;
      y        <= y_next;
      c        <= c_next;
      d        <= d_next;
      f        <= f_next;
      s1.func  <= r0.func;
      s1.a     <= r0.in_a;
      s1.b     <= r0.in_b;
      s1.alt   <= '0;
      num      <= prod[NW-1:0];
      den      <= d;
      side.func <= s1.func;
      side.a    <= s1.a;
      side.b    <= s1.b;
      side.alt  <= NW'(altp);
    end
  end

endmodule

[rtl/hgc_mid.sv]
// Middle stages: residual and rounding ahead of the second division.
module hgc_mid
  import hgc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [SW-1:0]        cell_size,
  input  logic                 in_valid,
  input  logic signed [NW-1:0] quo,
  input  side1_t               side_in,
  output logic                 out_valid,
  output logic signed [NW-1:0] num,
  output logic [DW-1:0]        den,
  output side2_t               side
);

  logic [SW-1:0]        s_r;
  logic [DW-2:0]        k_r;
  logic                 v1, v2;
  logic signed [QW-1:0] q;
  logic [DW-2:0]        mm;
  logic signed [QW+DW:0] pm;
  logic signed [NW-1:0] base, base_next, p, t;
  logic [DW-1:0]        m1, m1_next, m2, d1, d1_next, d2;
  side2_t               sd1, sd2;
  logic signed [NW-1:0] madd;

  always_ff @(posedge clk) begin
    s_r <= (cell_size == '0) ? SW'(1) : cell_size;
    k_r <= (DW-1)'(RT3_DEN2 * s_r);
  end

  assign q  = quo[QW-1:0];
  assign mm = (side_in.func == FN_S2V) ? (DW-1)'(s_r) : k_r;
  assign pm = q * $signed({1'b0, mm});

  always_comb begin
    base_next = '0;
    m1_next   = '0;
    d1_next   = DW'(1);
    case (side_in.func)
      FN_S2V: begin
        base_next = NW'(side_in.b);
        m1_next   = DW'(s_r);
        d1_next   = DW'({s_r, 1'b0});
      end
      FN_S2H: begin
        base_next = NW'(side_in.a) * $signed({1'b0, RT3_NUM});
        m1_next   = DW'(k_r);
        d1_next   = {k_r, 1'b0};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (t > 0) begin
      madd = NW'($signed({1'b0, m2}));
    end else if (t < 0) begin
      madd = -NW'($signed({1'b0, m2}));
    end else begin
      madd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base     <= base_next;
      p        <= (side_in.func == FN_S2V || side_in.func == FN_S2H) ? pm[NW-1:0] : '0;
      m1       <= m1_next;
      d1       <= d1_next;
      sd1.func <= side_in.func;
      sd1.q1   <= q;
      sd1.alt  <= side_in.alt;
      t        <= base - p;
      m2       <= m1;
      d2       <= d1;
      sd2      <= sd1;
      num      <= t + madd;
      den      <= d2;
      side     <= sd2;
    end
  end

endmodule

[rtl/hex_triangle_grid_coord_map.sv]
// Top level of the hexagonal grid coordinate mapper.
// Pipeline: 2 * CW + 55 register stages from request to result (87 at 16 bits).
// Throughput: one request per cycle unless stalled; two pipelined dividers set depth.
// A stalled result holds the whole pipeline in place.
// Reset clears all valid bits and sets cell_size to 3.
module hex_triangle_grid_coord_map
  import hgc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  req_t          req,
  output logic          res_valid,
  input  logic          res_ready,
  output res_t          res,
  input  logic          cfg_we,
  input  logic [SW-1:0] cfg_wdata
);

  localparam logic signed [NW-1:0] HI = NW'((64'(1) << (CW - 1)) - 64'(1));
  localparam logic signed [NW-1:0] LO = ~HI;

  logic [SW-1:0]        cell_size;
  logic                 en;
  logic                 f_v, d1_v, m_v, d2_v;
  logic signed [NW-1:0] f_num, d1_q, m_num, d2_q;
  logic [DW-1:0]        f_den, m_den;
  side1_t               f_sd, d1_sd;
  side2_t               m_sd, d2_sd;
  logic signed [NW-1:0] ra, rb;
  logic                 sat_a, sat_b;
  logic signed [CW-1:0] ca, cb;

  assign en        = !res_valid || res_ready;
  assign req_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size <= CELL_RESET;
    end else if (cfg_we) begin
      cell_size <= cfg_wdata;
    end
  end

  hgc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req_valid),
    .req       (req),
    .cell_size (cell_size),
    .out_valid (f_v),
    .num       (f_num),
    .den       (f_den),
    .side      (f_sd)
  );

  hgc_div #(.SIDE_W($bits(side1_t))) u_div1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_v),
    .num       (f_num),
    .den       (f_den),
    .side_in   (f_sd),
    .out_valid (d1_v),
    .quo       (d1_q),
    .side_out  (d1_sd)
  );

  hgc_mid u_mid (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cell_size (cell_size),
    .in_valid  (d1_v),
    .quo       (d1_q),
    .side_in   (d1_sd),
    .out_valid (m_v),
    .num       (m_num),
    .den       (m_den),
    .side      (m_sd)
  );

  hgc_div #(.SIDE_W($bits(side2_t))) u_div2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m_v),
    .num       (m_num),
    .den       (m_den),
    .side_in   (m_sd),
    .out_valid (d2_v),
    .quo       (d2_q),
    .side_out  (d2_sd)
  );

  always_comb begin
    ra = NW'(d2_sd.q1);
    rb = d2_sd.alt;
    case (d2_sd.func)
      FN_S2V: rb = d2_q;
      FN_S2H: begin
        ra = d2_q;
        rb = NW'(d2_sd.q1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sat_a = (ra > HI) || (ra < LO);
    sat_b = (rb > HI) || (rb < LO);
    ca = (ra > HI) ? HI[CW-1:0] : (ra < LO) ? LO[CW-1:0] : ra[CW-1:0];
    cb = (rb > HI) ? HI[CW-1:0] : (rb < LO) ? LO[CW-1:0] : rb[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.out_a     <= ca;
      res.out_b     <= cb;
      res.saturated <= sat_a || sat_b;
    end
  end

endmodule

[tb/tb_top.sv]
// Testbench for the hexagonal grid coordinate mapper against a predictor.
module tb_top;
  import hgc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 2 * CW + 55;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;
  logic cfg_we = 1'b0;
  logic [SW-1:0] cfg_wdata = '0;

  logic [SW-1:0] cell_cfg = CELL_RESET;
  res_t mapped_q[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int hold_off = 0;
  bit busy_recv = 1'b1;
  int fn_count[4];

  hex_triangle_grid_coord_map DUT (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint sign_of(longint n);
    return (n > 0) ? 1 : ((n < 0) ? -1 : 0);
  endfunction

  function automatic logic [CW-1:0] clamp(longint v, ref bit sat);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      v = hi;
      sat = 1'b1;
    end
    if (v < lo) begin
      v = lo;
      sat = 1'b1;
    end
    return v[CW-1:0];
  endfunction

  function automatic res_t map_coord(req_t r);
    longint a, b, s, ra, rb, t, k;
    bit sat;
    res_t o;
    a = longint'(r.in_a);
    b = longint'(r.in_b);
    s = (cell_cfg == 0) ? 1 : longint'(cell_cfg);
    sat = 1'b0;
    case (r.func)
      FN_S2V: begin
        ra = (2131 * (a + s)) / (3691 * s);
        t = b - s * ra;
        t += s * sign_of(t);
        rb = t / (s * 2);
      end
      FN_S2H: begin
        rb = (b + s) / (s * 2);
        k = 2131 * 2 * s;
        t = a * 3691 - rb * k;
        t += k * sign_of(t);
        ra = t / (k * 2);
      end
      FN_V2S: begin
        ra = (s * a * 3691) / 2131;
        rb = s * (2 * b + a);
      end
      default: begin
        s *= 2;
        rb = s * b;
        ra = (s * 2131 * (2 * a + b)) / 3691;
      end
    endcase
    o.out_a = clamp(ra, sat);
    o.out_b = clamp(rb, sat);
    o.saturated = sat;
    return o;
  endfunction

  task automatic send_request(func_t f, logic [CW-1:0] a, logic [CW-1:0] b, bit gaps);
    req_t r;
    while (gaps && $urandom_range(99) < 30) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    r.func = f;
    r.in_a = a;
    r.in_b = b;
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    mapped_q.insert(mapped_q.size(), map_coord(r));
    fn_count[f]++;
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(negedge clk);
    while (mapped_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_cell(logic [SW-1:0] v);
    drain();
    repeat (LATENCY + 5) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    cell_cfg = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CW-1:0] edge_val(int i);
    case (i % 6)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return 16'h0001;
      default: return CW'($urandom());
    endcase
  endfunction

  task automatic test_directed();
    for (int i = 0; i < 24; i++)
      send_request(func_t'(i % 4), edge_val(i), edge_val(i / 4 + 1), 1'b0);
    drain();
  endtask

  task automatic test_random(int n, bit gaps);
    logic [CW-1:0] a, b;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        a = CW'($urandom());
        b = CW'($urandom());
      end else begin
        a = CW'($urandom_range(2000) - 1000);
        b = CW'($urandom_range(2000) - 1000);
      end
      send_request(func_t'($urandom_range(3)), a, b, gaps);
    end
  endtask

  task automatic test_backpressure();
    hold_off = 200;
    test_random(150, 1'b0);
    drain();
  endtask

  task automatic test_cell_sizes();
    logic [SW-1:0] sizes[6] = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd17, 8'd128};
    foreach (sizes[i]) begin
      write_cell(sizes[i]);
      test_directed();
      test_random(50, 1'b1);
    end
    drain();
  endtask

  always @(negedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res_ready <= 1'b0;
    end else begin
      res_ready <= busy_recv ? ($urandom_range(99) >= 30) : 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t exp_r;
    if (!rst && res_valid && res_ready) begin
      if (mapped_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, res);
        errors++;
      end else begin
        exp_r = mapped_q.pop_front();
        checked++;
        if (res.out_a !== exp_r.out_a)
          $display("%0t: out_a expected %0d actual %0d", $time, exp_r.out_a, res.out_a);
        if (res.out_b !== exp_r.out_b)
          $display("%0t: out_b expected %0d actual %0d", $time, exp_r.out_b, res.out_b);
        if (res.saturated !== exp_r.saturated)
          $display("%0t: saturated expected %0b actual %0b", $time, exp_r.saturated,
                   res.saturated);
        if (res !== exp_r) errors++;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(150, 1'b1);
    busy_recv = 1'b0;
    test_random(100, 1'b0);
    busy_recv = 1'b1;
    test_backpressure();
    test_cell_sizes();
    write_cell(CELL_RESET);
    drain();
    repeat (LATENCY + 10) @(negedge clk);
    $display("Sent %0d requests over several cell sizes incl. 0 and 255 (funcs %0d/%0d/%0d/%0d),",
             sent, fn_count[0], fn_count[1], fn_count[2], fn_count[3]);
    $display("with edge values, random stalls and a long output hold; %0d checked.", checked);
    if (errors == 0 && mapped_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end
endmodule

[hex_triangle_grid_coord_map.f]
rtl/hgc_pkg.sv
rtl/hgc_div.sv
rtl/hgc_front.sv
rtl/hgc_mid.sv
rtl/hex_triangle_grid_coord_map.sv
tb/tb_top.sv
